// ----- design/dsm_pkg.sv -----
// Shared constants and types for the dot-star pattern matcher.
package dsm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int ROW_W       = MAX_PATTERN + 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CHARS_LOW   = CFG_W / 8;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_STAR = 8'h2A;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = CFG_IDX_W'(2);

    // Pattern as seen by the row logic; length is already limited to MAX_PATTERN.
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] chars;
        logic [LEN_W-1:0]            len;
    } t_pattern;

endpackage

// ----- design/dsm_cfg_regs.sv -----
// Configuration registers holding the pattern and its length.
module dsm_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dsm_pkg::CFG_W-1:0]       i_cfg_data,
    output dsm_pkg::t_pattern               o_pattern
);

    logic [dsm_pkg::CFG_W-1:0] r_pat_low;
    logic [dsm_pkg::CFG_W-1:0] r_pat_high;
    logic [dsm_pkg::LEN_W-1:0] r_pat_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dsm_pkg::CFG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                dsm_pkg::CFG_PAT_HIGH: r_pat_high <= i_cfg_data;
                dsm_pkg::CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[dsm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < dsm_pkg::MAX_PATTERN; k++) begin
            if (k < dsm_pkg::CHARS_LOW) begin
                o_pattern.chars[k] = r_pat_low[8*(k % dsm_pkg::CHARS_LOW) +: 8];
            end else begin
                o_pattern.chars[k] = r_pat_high[8*(k % dsm_pkg::CHARS_LOW) +: 8];
            end
        end
        // Lengths beyond the pattern storage are treated as full length.
        if (r_pat_len > dsm_pkg::LEN_W'(dsm_pkg::MAX_PATTERN)) begin
            o_pattern.len = dsm_pkg::LEN_W'(dsm_pkg::MAX_PATTERN);
        end else begin
            o_pattern.len = r_pat_len;
        end
    end

endmodule

// ----- design/dsm_row_update.sv -----
// Next match row and match flag for one text beat.
module dsm_row_update (
    input  dsm_pkg::t_pattern                i_pattern,
    input  logic [dsm_pkg::ROW_W-1:0]        i_row,
    input  logic                             i_mode,
    input  logic [7:0]                       i_text_byte,
    output logic [dsm_pkg::ROW_W-1:0]        o_row_next,
    output logic                             o_matched
);

    logic [dsm_pkg::ROW_W-1:0] in_use;
    logic [dsm_pkg::ROW_W-1:0] star_col;
    logic [dsm_pkg::ROW_W-1:0] fits;
    logic [dsm_pkg::ROW_W-1:0] closed;
    logic [dsm_pkg::ROW_W-1:0] stepped;

    always_comb begin
        in_use   = '0;
        star_col = '0;
        fits     = '0;
        for (int j = 0; j < dsm_pkg::ROW_W; j++) begin
            in_use[j] = (dsm_pkg::LEN_W'(j) <= i_pattern.len);
        end
        // fits[j]: byte matches pattern character j-1.
        for (int j = 1; j < dsm_pkg::ROW_W; j++) begin
            fits[j] = (i_pattern.chars[j-1] == i_text_byte) ||
                      (i_pattern.chars[j-1] == dsm_pkg::CH_DOT);
        end
        for (int j = 2; j < dsm_pkg::ROW_W; j++) begin
            star_col[j] = (i_pattern.chars[j-1] == dsm_pkg::CH_STAR);
        end

        // Close the stored row under the star skip rule; a new text starts from column zero.
        closed = (i_mode ? i_row : dsm_pkg::ROW_W'(1)) & in_use;
        for (int j = 2; j < dsm_pkg::ROW_W; j++) begin
            if (star_col[j] && closed[j-2] && in_use[j]) begin
                closed[j] = 1'b1;
            end
        end

        // Column one is never a star column, since a leading star is a literal.
        stepped    = '0;
        stepped[1] = in_use[1] && fits[1] && closed[0];
        for (int j = 2; j < dsm_pkg::ROW_W; j++) begin
            if (in_use[j]) begin
                if (star_col[j]) begin
                    stepped[j] = stepped[j-2] || (fits[j-1] && closed[j]);
                end else begin
                    stepped[j] = fits[j] && closed[j-1];
                end
            end
        end

        if (i_mode) begin
            o_row_next = stepped;
            o_matched  = stepped[i_pattern.len];
        end else begin
            o_row_next = dsm_pkg::ROW_W'(1);
            o_matched  = closed[i_pattern.len];
        end
    end

endmodule

// ----- design/dot_star_pattern_matcher.sv -----
// Top level of the dot-star pattern matcher: handshake stages and match row.
//
// Usage: the pattern (literal bytes, '.' for any byte, 'x*' for zero or more
// of the preceding element) is written through the configuration port while
// the block is idle: index 0 holds characters 0 to 7, index 1 characters 8
// to 15, index 2 the pattern length. A '*' in the first position is literal.
// Text arrives on the input channel, one beat per byte. A beat with mode 0
// starts a new empty text, mode 1 appends the byte. Every input beat yields
// exactly one output beat telling whether the whole text so far matches.
// The input register captures the beat; the row update and result register
// are written once the output register is free. Throughput is one beat per
// cycle unless the receiver stalls; the whole row update for one beat is a
// single combinational pass of at most 17 columns next to the row register.
// When the receiver stalls, the result holds in the output register and one
// more beat can still be taken into the input register before o_stall rises.
// Reset clears both stages, the configuration and sets the match row to
// column zero only, which is the row of an empty text.
module dot_star_pattern_matcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dsm_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_mode,
    input  logic [7:0]                      i_text_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_matched
);

    dsm_pkg::t_pattern pattern;

    logic                       r_in_valid;
    logic                       r_in_mode;
    logic [7:0]                 r_in_byte;
    logic [dsm_pkg::ROW_W-1:0]  r_row;
    logic                       r_out_valid;
    logic                       r_out_matched;

    logic                       out_free;
    logic                       fire;
    logic                       in_take;
    logic [dsm_pkg::ROW_W-1:0]  n_row;
    logic                       n_matched;

    dsm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pattern  (pattern)
    );

    dsm_row_update u_row (
        .i_pattern   (pattern),
        .i_row       (r_row),
        .i_mode      (r_in_mode),
        .i_text_byte (r_in_byte),
        .o_row_next  (n_row),
        .o_matched   (n_matched)
    );

    // The output register is free when empty or when its beat leaves this cycle.
    assign out_free = !r_out_valid || !i_stall;
    // The beat in the input register is processed when the result can be stored.
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_row       <= dsm_pkg::ROW_W'(1);
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_row       <= n_row;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode <= i_mode;
            r_in_byte <= i_text_byte;
        end
        if (fire) begin
            r_out_matched <= n_matched;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_matched = r_out_matched;

`ifndef SYNTH
    // Reset leaves the row of an empty text.
    a_reset_row: assert property (@(posedge i_clk)
        !i_rst_n |=> r_row == dsm_pkg::ROW_W'(1))
        else $error("match row not at empty-text value after reset");

    // A new-text beat leaves only column zero set.
    a_new_text_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !r_in_mode |=> r_row == dsm_pkg::ROW_W'(1))
        else $error("match row wrong after new-text beat");

    // Backpressure is raised only by a full, stalled pipeline.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("stall raised without a blocked result");

    // A waiting input beat is neither dropped nor processed twice.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_mode))
        else $error("input beat lost while waiting");

    // The row only changes when a beat is processed.
    a_row_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_row))
        else $error("match row changed without a beat");
`endif

endmodule
